@@ rtl/nsp_pkg.sv @@
// shared types and character codes for the nmea sentence parser
package nsp_pkg;

    localparam int MAX_FIELDS = 32;
    localparam int FIELD_W    = 6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ADDR = 3'd1,
        PH_DATA = 3'd2,
        PH_OVER = 3'd3,
        PH_SUM  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] field_index;
        logic [7:0]         char_value;
        logic [15:0]        talker_id;
        logic [23:0]        sentence_type;
        logic [FIELD_W-1:0] field_count;
        logic [7:0]         checksum_calc;
    } t_result;

endpackage

@@ rtl/nsp_core.sv @@
// per-byte sentence state and result decode
module nsp_core import nsp_pkg::*; #(
    parameter int MAX_FIELDS = nsp_pkg::MAX_FIELDS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte_value,
    input  logic       i_checksum_enable,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase             r_phase, n_phase;
    logic [7:0]         r_xor_sum, n_xor_sum;
    logic [7:0]         r_recv_sum, n_recv_sum;
    logic [FIELD_W-1:0] r_field_num, n_field_num;
    logic [2:0]         r_addr_pos, n_addr_pos;
    logic [15:0]        r_talker, n_talker;
    logic [23:0]        r_type, n_type;
    logic               r_error, n_error;
    logic               r_star, n_star;

    logic [4:0]         hex;
    logic               ok;

    // bit 4 flags a valid hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) v = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) v = {1'b1, 4'(c - 8'h37)};
        return v;
    endfunction

    always_comb begin
        n_phase     = r_phase;
        n_xor_sum   = r_xor_sum;
        n_recv_sum  = r_recv_sum;
        n_field_num = r_field_num;
        n_addr_pos  = r_addr_pos;
        n_talker    = r_talker;
        n_type      = r_type;
        n_error     = r_error;
        n_star      = r_star;
        o_res_valid = 1'b0;
        o_res       = '0;
        hex         = hex_decode(i_byte_value);
        ok          = 1'b1;
        if (i_checksum_enable) begin
            ok = r_star && !r_error && (r_addr_pos == 3'd2) && (r_recv_sum == r_xor_sum)
                 && (r_phase == PH_SUM);
        end
        if (i_accept) begin
            if (i_byte_value == CH_DOLLAR) begin
                n_phase     = PH_ADDR;
                n_xor_sum   = 8'd0;
                n_recv_sum  = 8'd0;
                n_field_num = '0;
                n_addr_pos  = 3'd0;
                n_talker    = 16'd0;
                n_type      = 24'd0;
                n_error     = 1'b0;
                n_star      = 1'b0;
            end else if (r_phase == PH_IDLE) begin
                // outside a sentence, ignored
            end else if (i_byte_value == CH_CR) begin
                o_res_valid         = 1'b1;
                o_res.kind          = ok ? KIND_ACCEPT : KIND_REJECT;
                o_res.talker_id     = r_talker;
                o_res.sentence_type = r_type;
                o_res.field_count   = r_field_num;
                o_res.checksum_calc = r_xor_sum;
                n_phase             = PH_IDLE;
            end else if (r_phase == PH_SUM) begin
                if (!hex[4] || r_addr_pos >= 3'd2) begin
                    n_error = 1'b1;
                end else begin
                    n_recv_sum = {r_recv_sum[3:0], hex[3:0]};
                    n_addr_pos = r_addr_pos + 3'd1;
                end
            end else if (i_byte_value == CH_STAR) begin
                if (r_phase == PH_DATA) begin
                    o_res_valid       = 1'b1;
                    o_res.kind        = KIND_FIELD;
                    o_res.field_index = r_field_num;
                end
                n_star     = 1'b1;
                n_recv_sum = 8'd0;
                n_addr_pos = 3'd0;
                n_phase    = PH_SUM;
            end else begin
                n_xor_sum = r_xor_sum ^ i_byte_value;
                case (r_phase)
                    PH_ADDR: begin
                        if (i_byte_value == CH_COMMA) begin
                            n_field_num = FIELD_W'(1);
                            n_phase     = PH_DATA;
                        end else begin
                            case (r_addr_pos)
                                3'd0: n_talker[15:8] = i_byte_value;
                                3'd1: n_talker[7:0]  = i_byte_value;
                                3'd2: n_type[23:16]  = i_byte_value;
                                3'd3: n_type[15:8]   = i_byte_value;
                                3'd4: n_type[7:0]    = i_byte_value;
                                default: ;
                            endcase
                            if (r_addr_pos < 3'd5) n_addr_pos = r_addr_pos + 3'd1;
                        end
                    end
                    PH_DATA: begin
                        o_res_valid       = 1'b1;
                        o_res.field_index = r_field_num;
                        if (i_byte_value == CH_COMMA) begin
                            o_res.kind = KIND_FIELD;
                            if (r_field_num >= FIELD_W'(MAX_FIELDS)) begin
                                n_error = 1'b1;
                                n_phase = PH_OVER;
                            end else begin
                                n_field_num = r_field_num + FIELD_W'(1);
                            end
                        end else begin
                            o_res.kind       = KIND_DATA;
                            o_res.char_value = i_byte_value;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_xor_sum   <= 8'd0;
            r_recv_sum  <= 8'd0;
            r_field_num <= '0;
            r_addr_pos  <= 3'd0;
            r_talker    <= 16'd0;
            r_type      <= 24'd0;
            r_error     <= 1'b0;
            r_star      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_xor_sum   <= n_xor_sum;
            r_recv_sum  <= n_recv_sum;
            r_field_num <= n_field_num;
            r_addr_pos  <= n_addr_pos;
            r_talker    <= n_talker;
            r_type      <= n_type;
            r_error     <= n_error;
            r_star      <= n_star;
        end
    end

endmodule

@@ rtl/nmea_sentence_parser.sv @@
// nmea 0183 sentence parser top level with output register and skid stage
// a result request is registered into the output slot, or into the skid stage behind a stalled output
// throughput: one byte per cycle while the input is not stalled, set by the registered state update in nsp_core
// input stalls only while the skid stage holds a request behind a stalled output
// reset: synchronous active-low, clears sentence state, checksum enable and both
// output slots; the input does not stall coming out of reset
module nmea_sentence_parser import nsp_pkg::*; #(
    parameter int MAX_FIELDS = nsp_pkg::MAX_FIELDS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    // byte input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_byte_value,
    // result output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_kind,
    output logic [FIELD_W-1:0] o_field_index,
    output logic [7:0]         o_char_value,
    output logic [15:0]        o_talker_id,
    output logic [23:0]        o_sentence_type,
    output logic [FIELD_W-1:0] o_field_count,
    output logic [7:0]         o_checksum_calc
);

    logic    r_checksum_enable;
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    logic    in_accept;
    logic    out_take;
    logic    res_valid;
    t_result res;

    // skid full means the next request may have nowhere to go
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    nsp_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_byte_value      (i_byte_value),
        .i_checksum_enable (r_checksum_enable),
        .o_res_valid       (res_valid),
        .o_res             (res)
    );

    // checksum enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_checksum_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_checksum_enable <= i_cfg_wr_data;
        end
    end

    // output control: the skid drains first, new requests fill the free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= res_valid;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (out_take && r_skid_valid) begin
            r_out <= r_skid;
        end else if (out_take || !r_out_valid) begin
            r_out <= res;
        end
        if (r_out_valid && !out_take && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_field_index   = r_out.field_index;
    assign o_char_value    = r_out.char_value;
    assign o_talker_id     = r_out.talker_id;
    assign o_sentence_type = r_out.sentence_type;
    assign o_field_count   = r_out.field_count;
    assign o_checksum_calc = r_out.checksum_calc;

endmodule

@@ tb/nsp_result_checker.sv @@
// result checker for the nmea sentence parser: tracks sentence state and compares every result
module nsp_result_checker import nsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_byte_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_kind,
    input  logic [FIELD_W-1:0] i_field_index,
    input  logic [7:0]         i_char_value,
    input  logic [15:0]        i_talker_id,
    input  logic [23:0]        i_sentence_type,
    input  logic [FIELD_W-1:0] i_field_count,
    input  logic [7:0]         i_checksum_calc,
    output int                 o_error_count,
    output int                 o_pending
);

    t_result            expected_q[$];
    int                 mismatch_total = 0;
    int                 pending_r = 0;

    bit                 sum_check_en;
    t_phase             cur_phase;
    logic [7:0]         run_xor;
    logic [7:0]         rx_sum;
    logic [FIELD_W-1:0] field_no;
    logic [2:0]         addr_pos;
    logic [15:0]        talker_acc;
    logic [23:0]        type_acc;
    bit                 err_flag;
    bit                 star_flag;

    assign o_error_count = mismatch_total;
    assign o_pending     = pending_r;

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        if (mismatch_total < 100) begin
            $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        end
        mismatch_total++;
    endtask

    task automatic clear_sentence();
        run_xor    = '0;
        rx_sum     = '0;
        field_no   = '0;
        addr_pos   = '0;
        talker_acc = '0;
        type_acc   = '0;
        err_flag   = 1'b0;
        star_flag  = 1'b0;
    endtask

    // {digit ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [7:0] d;
        if (ch >= "0" && ch <= "9") begin
            d = ch - "0";
            return {1'b1, d[3:0]};
        end
        if (ch >= "a" && ch <= "f") begin
            d = ch - "a" + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (ch >= "A" && ch <= "F") begin
            d = ch - "A" + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    task automatic parse_byte(input logic [7:0] ch, output bit emits, output t_result res);
        logic [4:0] hx;
        bit         ok;
        emits = 1'b0;
        res   = '0;
        if (ch == CH_DOLLAR) begin
            // a new dollar drops whatever sentence was open
            clear_sentence();
            cur_phase = PH_ADDR;
        end else if (cur_phase == PH_IDLE) begin
            // outside a sentence
        end else if (ch == CH_CR) begin
            ok = !sum_check_en || (cur_phase == PH_SUM && star_flag && !err_flag &&
                                   addr_pos == 3'd2 && rx_sum == run_xor);
            emits             = 1'b1;
            res.kind          = ok ? KIND_ACCEPT : KIND_REJECT;
            res.talker_id     = talker_acc;
            res.sentence_type = type_acc;
            res.field_count   = field_no;
            res.checksum_calc = run_xor;
            cur_phase         = PH_IDLE;
        end else if (cur_phase == PH_SUM) begin
            hx = hex_digit(ch);
            if (!hx[4] || addr_pos >= 3'd2) begin
                err_flag = 1'b1;
            end else begin
                rx_sum   = {rx_sum[3:0], hx[3:0]};
                addr_pos = addr_pos + 3'd1;
            end
        end else if (ch == CH_STAR) begin
            if (cur_phase == PH_DATA) begin
                emits           = 1'b1;
                res.kind        = KIND_FIELD;
                res.field_index = field_no;
            end
            star_flag = 1'b1;
            rx_sum    = '0;
            addr_pos  = '0;
            cur_phase = PH_SUM;
        end else begin
            run_xor = run_xor ^ ch;
            case (cur_phase)
                PH_ADDR: begin
                    if (ch == CH_COMMA) begin
                        field_no  = FIELD_W'(1);
                        cur_phase = PH_DATA;
                    end else if (addr_pos < 3'd5) begin
                        case (addr_pos)
                            3'd0:    talker_acc[15:8] = ch;
                            3'd1:    talker_acc[7:0]  = ch;
                            3'd2:    type_acc[23:16]  = ch;
                            3'd3:    type_acc[15:8]   = ch;
                            default: type_acc[7:0]    = ch;
                        endcase
                        addr_pos = addr_pos + 3'd1;
                    end
                end
                PH_DATA: begin
                    emits           = 1'b1;
                    res.field_index = field_no;
                    if (ch == CH_COMMA) begin
                        res.kind = KIND_FIELD;
                        if (field_no >= MAX_FIELDS) begin
                            err_flag  = 1'b1;
                            cur_phase = PH_OVER;
                        end else begin
                            field_no = field_no + 1'b1;
                        end
                    end else begin
                        res.kind       = KIND_DATA;
                        res.char_value = ch;
                    end
                end
                default: begin
                    // overflowed sentence: only the xor moves
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result res;
        bit      emits;
        if (!i_rst_n) begin
            sum_check_en = 1'b0;
            cur_phase    = PH_IDLE;
            clear_sentence();
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result kind with nothing pending", i_kind, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_kind != want.kind)
                        report_mismatch("kind", i_kind, want.kind);
                    if (i_field_index != want.field_index)
                        report_mismatch("field_index", i_field_index, want.field_index);
                    if (i_char_value != want.char_value)
                        report_mismatch("char_value", i_char_value, want.char_value);
                    if (i_talker_id != want.talker_id)
                        report_mismatch("talker_id", i_talker_id, want.talker_id);
                    if (i_sentence_type != want.sentence_type)
                        report_mismatch("sentence_type", i_sentence_type, want.sentence_type);
                    if (i_field_count != want.field_count)
                        report_mismatch("field_count", i_field_count, want.field_count);
                    if (i_checksum_calc != want.checksum_calc)
                        report_mismatch("checksum_calc", i_checksum_calc, want.checksum_calc);
                end
            end
            if (i_cfg_wr_en) begin
                sum_check_en = i_cfg_wr_data;
            end
            if (i_in_valid && !i_in_stall) begin
                parse_byte(i_byte_value, emits, res);
                if (emits) begin
                    expected_q.insert(expected_q.size(), res);
                end
            end
        end
        pending_r <= expected_q.size();
    end

endmodule

@@ tb/nmea_sentence_parser_test.sv @@
// testbench top for the nmea sentence parser: byte stimulus, output stalls and verdict
module nmea_sentence_parser_test;
    import nsp_pkg::*;

    localparam int IDLE_PCT    = 24;      // percent of cycles a side idles
    localparam int HOLD_CYCLES = 60;      // long receiver hold-off
    localparam int PHASE_BYTES = 10;      // minimum random bytes per configuration phase, four times this in phase 1
    localparam int LIMIT       = 100000;  // cycle budget for the whole run

    // how a sentence is closed after its body
    typedef enum int {
        SUM_GOOD_LOWER,
        SUM_GOOD_UPPER,
        SUM_WRONG,
        SUM_NONE,
        SUM_BAD_DIGIT,
        SUM_SHORT,
        SUM_LONG,
        SUM_EMPTY,
        SUM_CUT
    } t_sum_mode;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               in_valid = 1'b0;
    logic [7:0]         byte_value = 8'h00;
    logic               out_stall = 1'b0;
    wire                in_stall;
    wire                out_valid;
    wire  [1:0]         kind;
    wire  [FIELD_W-1:0] field_index;
    wire  [7:0]         char_value;
    wire  [15:0]        talker_id;
    wire  [23:0]        sentence_type;
    wire  [FIELD_W-1:0] field_count;
    wire  [7:0]         checksum_calc;

    int                 error_count;
    int                 pending;
    int                 cycle_count = 0;
    int                 sent_total = 0;
    bit                 idle_on = 1'b1;
    bit                 hold_trigger = 1'b0;
    bit                 hold_seen = 1'b0;
    int                 hold_left = 0;
    logic [7:0]         body[$];          // sentence text between dollar and star

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    nmea_sentence_parser dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_byte_value    (byte_value),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_kind          (kind),
        .o_field_index   (field_index),
        .o_char_value    (char_value),
        .o_talker_id     (talker_id),
        .o_sentence_type (sentence_type),
        .o_field_count   (field_count),
        .o_checksum_calc (checksum_calc)
    );

    nsp_result_checker sentence_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_byte_value    (byte_value),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_kind          (kind),
        .i_field_index   (field_index),
        .i_char_value    (char_value),
        .i_talker_id     (talker_id),
        .i_sentence_type (sentence_type),
        .i_field_count   (field_count),
        .i_checksum_calc (checksum_calc),
        .o_error_count   (error_count),
        .o_pending       (pending)
    );

    // watchdog on the whole run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stalls while idling is on, plus a long hold-off whenever the trigger flips
    always @(posedge clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // one byte request; returns at the edge that accepts it with valid still high
    task automatic send_byte(input logic [7:0] b);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_total++;
    endtask

    // stop offering and let every pending result drain, plus the output latency
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_check_enable(input bit en);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            body.insert(body.size(), s[i]);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return "0" + n;
        return (upper ? "A" : "a") + n - 8'd10;
    endfunction

    // any byte that cannot end a field or a sentence
    function automatic logic [7:0] rand_field_byte();
        logic [7:0] b;
        do begin
            b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(126, 32));
        end while (b == CH_DOLLAR || b == CH_COMMA || b == CH_STAR || b == CH_CR);
        return b;
    endfunction

    // dollar, body, then the checksum tail the mode asks for, then cr lf unless the mode cuts the sentence
    task automatic send_sentence(input t_sum_mode mode);
        logic [7:0] sum;
        string      non_hex;
        bit         upper;
        sum     = 8'h00;
        non_hex = "gGxZ*,. ~";
        upper   = (mode == SUM_GOOD_UPPER) || $urandom_range(1);
        send_byte(CH_DOLLAR);
        foreach (body[i]) begin
            send_byte(body[i]);
            sum ^= body[i];
        end
        if (mode == SUM_WRONG) begin
            sum ^= 8'($urandom_range(255, 1));
        end
        if (mode == SUM_GOOD_LOWER) begin
            upper = 1'b0;
        end
        if (mode != SUM_NONE && mode != SUM_CUT) begin
            send_byte(CH_STAR);
        end
        case (mode)
            SUM_GOOD_LOWER, SUM_GOOD_UPPER, SUM_WRONG, SUM_LONG: begin
                send_byte(hex_char(sum[7:4], upper));
                send_byte(hex_char(sum[3:0], upper));
                if (mode == SUM_LONG) send_byte(hex_char(4'($urandom_range(15)), upper));
            end
            SUM_BAD_DIGIT: begin
                send_byte(hex_char(sum[7:4], upper));
                send_byte(($urandom_range(4) == 0) ? 8'hFF :
                          non_hex[$urandom_range(non_hex.len() - 1)]);
            end
            SUM_SHORT: send_byte(hex_char(sum[7:4], upper));
            default: begin
                // no digits at all
            end
        endcase
        if (mode != SUM_CUT) begin
            send_byte(CH_CR);
            send_byte(8'h0A);
        end
        body.delete();
    endtask

    // mostly well-formed sentences with random content, some broken ones
    task automatic send_random_sentence();
        int        addr_len;
        int        nfld;
        int        pick;
        t_sum_mode mode;
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
        end
        addr_len = ($urandom_range(99) < 85) ? 5 : $urandom_range(7);
        repeat (addr_len) begin
            // upper-case letters mostly
            body.insert(body.size(), ($urandom_range(3) != 0) ?
                        8'($urandom_range(8'h5A, 8'h41)) : rand_field_byte());
        end
        pick = $urandom_range(99);
        nfld = (pick < 80) ? $urandom_range(6) :
               (pick < 95) ? $urandom_range(14, 7) : $urandom_range(MAX_FIELDS + 3, MAX_FIELDS - 2);
        repeat (nfld) begin
            body.insert(body.size(), CH_COMMA);
            repeat ($urandom_range(3)) body.insert(body.size(), rand_field_byte());
        end
        // broken sentence: a stray byte of any value somewhere in the body
        if ($urandom_range(99) < 12) begin
            body.insert($urandom_range(body.size()), 8'($urandom_range(255)));
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            mode = pick[0] ? SUM_GOOD_UPPER : SUM_GOOD_LOWER;
        end else begin
            mode = t_sum_mode'($urandom_range(SUM_CUT, SUM_WRONG));
        end
        send_sentence(mode);
    endtask

    initial begin
        int phase_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_check_enable(1'b1);

        // bytes outside any sentence are dropped
        send_byte("x");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(8'h0A);
        // plain sentence with an empty field in the middle and at the end
        put_str("GPGGA,123,,4.5,N,");
        send_sentence(SUM_GOOD_UPPER);
        put_str("GNRMC,,a");
        send_sentence(SUM_GOOD_LOWER);
        // checksum failures of every sort
        put_str("GPVTG,1");
        send_sentence(SUM_WRONG);
        put_str("GPGLL,2");
        send_sentence(SUM_NONE);
        put_str("GPGSA,3");
        send_sentence(SUM_BAD_DIGIT);
        put_str("GPGSA,4");
        send_sentence(SUM_SHORT);
        put_str("GPGSA,5");
        send_sentence(SUM_LONG);
        put_str("GPGSA,6");
        send_sentence(SUM_EMPTY);
        // dollar inside an open sentence restarts it
        put_str("GPXTE,9,9");
        send_sentence(SUM_CUT);
        put_str("GPZDA,7");
        send_sentence(SUM_GOOD_LOWER);
        // address longer than five, address closed by star, by cr, short and empty
        put_str("GPGSVEXTRA,1");
        send_sentence(SUM_GOOD_UPPER);
        put_str("GPZDA");
        send_sentence(SUM_GOOD_UPPER);
        put_str("GPZ");
        send_sentence(SUM_NONE);
        send_sentence(SUM_GOOD_LOWER);
        // data bytes at the extremes
        put_str("HCHDG,");
        body.insert(body.size(), 8'hFF);
        body.insert(body.size(), 8'h00);
        body.insert(body.size(), 8'h80);
        put_str(",7F");
        send_sentence(SUM_GOOD_UPPER);
        // field overflow with checking on, then off
        put_str("GPOVF");
        repeat (MAX_FIELDS + 2) put_str(",z");
        send_sentence(SUM_GOOD_UPPER);
        write_check_enable(1'b0);
        put_str("GPOVF");
        repeat (MAX_FIELDS + 2) put_str(",");
        send_sentence(SUM_GOOD_LOWER);
        put_str("GPVTG,1");
        send_sentence(SUM_WRONG);

        // random phases: check off, check on without idling, on with a hold-off, off
        for (int p = 0; p < 4; p++) begin
            write_check_enable(p == 1 || p == 2);
            idle_on = (p != 1);
            if (p == 2) begin
                // long output hold while a long field keeps the input busy
                hold_trigger <= ~hold_trigger;
                put_str("GPTXT,");
                repeat (30) body.insert(body.size(), rand_field_byte());
                send_sentence(SUM_GOOD_UPPER);
            end
            phase_start = sent_total;
            while (sent_total - phase_start < ((p == 1) ? 4 * PHASE_BYTES : PHASE_BYTES)) begin
                send_random_sentence();
            end
        end
        idle_on = 1'b1;

        drain();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/nsp_pkg.sv
rtl/nsp_core.sv
rtl/nmea_sentence_parser.sv
tb/nsp_result_checker.sv
tb/nmea_sentence_parser_test.sv
